// ----- sv/ctmt_pkg.sv -----
package ctmt_pkg;

    // Field and register widths
    localparam int CYC_W    = 32;
    localparam int TICK_W   = 32;
    localparam int US_W     = 64;
    localparam int MS_W     = 32;
    localparam int STEP_W   = 32;
    localparam int CPU_HZ_W = 32;
    localparam int TICK_HZ_W = 20;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_CLOCK_HZ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE_HZ = 1'b1;

    // Constants
    localparam logic [CPU_HZ_W-1:0]  DEFAULT_CPU_HZ  = 32'd216000000;
    localparam logic [TICK_HZ_W-1:0] DEFAULT_TICK_HZ = 20'd1000;
    localparam int                   MUL_BITS        = 20;
    localparam logic [MUL_BITS-1:0]  US_PER_SEC      = 20'd1000000;
    localparam logic [CPU_HZ_W-1:0]  US_PER_MS       = 32'd1000;

    // Shared divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int MUL_CNT_W = $clog2(MUL_BITS);

endpackage

// ----- sv/ctmt_div.sv -----
module ctmt_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ctmt_pkg::DIV_NUM_W-1:0]     dividend,
    input  logic [ctmt_pkg::DIV_DEN_W-1:0]     divisor,
    output logic [ctmt_pkg::DIV_NUM_W-1:0]     quotient,
    output logic [ctmt_pkg::DIV_DEN_W-1:0]     remainder,
    output logic                               done
);
    import ctmt_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_NUM_W - 1);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 q_bit;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        q_bit = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_NUM_W-2:0], q_bit};
            rem_next = q_bit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- sv/cycle_to_microsecond_timebase_unit.sv -----
// Cycle counter to microsecond timebase. Each input word carries a sample of a
// free-running 32-bit cycle counter and the scheduler tick count; each yields
// exactly one output word. The first word after reset seeds the total as
// boot_ticks*1e6/tick_rate_hz and reports a step of zero. Later words take the
// cycle delta modulo 2^32, scale it by 1e6, add the kept fraction, divide by
// the clock rate, add the 32-bit quotient to the 64-bit total and keep the
// remainder as the new fraction. A zero clock rate reads as 216 MHz and a zero
// tick rate as 1000 Hz. One word is in flight at a time; from acceptance to
// the output register it passes through a bit-serial multiply by 1e6, a state
// that adds the fraction, then two passes of a shared radix-2 divider (one for
// the step, one for micros/1000). The output register frees the input side: a
// new word may be taken while the previous result still waits on out_stall.
// Write the config registers only while idle.
module cycle_to_microsecond_timebase_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_write,
    input  logic [ctmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctmt_pkg::CFG_W-1:0]        cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ctmt_pkg::CYC_W-1:0]        cycle_sample,
    input  logic [ctmt_pkg::TICK_W-1:0]       boot_ticks,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ctmt_pkg::US_W-1:0]         micros_now,
    output logic [ctmt_pkg::MS_W-1:0]         millis_now,
    output logic [ctmt_pkg::STEP_W-1:0]       step_us,
    output logic [ctmt_pkg::STEP_W-1:0]       largest_step_us
);
    import ctmt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,  // wait for an input word
        S_MUL   = 7'b0000010,  // shift-add multiply by 1e6
        S_ADDF  = 7'b0000100,  // add fraction, launch step division
        S_DIV   = 7'b0001000,  // wait for step quotient
        S_MSST  = 7'b0010000,  // launch micros/1000
        S_MS    = 7'b0100000,  // wait for millis quotient
        S_OUT   = 7'b1000000   // hand result to the output register
    } state_t;

    state_t state_reg, state_next;

    // Config registers
    logic [CPU_HZ_W-1:0]  cpu_hz_reg, cpu_hz_next;
    logic [TICK_HZ_W-1:0] tick_hz_reg, tick_hz_next;
    logic [CPU_HZ_W-1:0]  cpu_hz_eff;
    logic [TICK_HZ_W-1:0] tick_hz_eff;

    // Timebase state
    logic                 seeded_reg, seeded_next;
    logic [CYC_W-1:0]     prev_cyc_reg, prev_cyc_next;
    logic [US_W-1:0]      total_reg, total_next;
    logic [CPU_HZ_W-1:0]  frac_reg, frac_next;
    logic [STEP_W-1:0]    max_reg, max_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [MS_W-1:0]      millis_reg, millis_next;

    // Multiply datapath
    logic [CYC_W-1:0]     mul_x_reg, mul_x_next;
    logic [US_W-1:0]      acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic [US_W-1:0]      acc_plus_frac;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [US_W-1:0]      out_us_reg, out_us_next;
    logic [MS_W-1:0]      out_ms_reg, out_ms_next;
    logic [STEP_W-1:0]    out_step_reg, out_step_next;
    logic [STEP_W-1:0]    out_max_reg, out_max_next;

    // Divider hookup
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic [DIV_NUM_W-1:0] div_quotient;
    logic [DIV_DEN_W-1:0] div_remainder;
    logic                 div_done;

    logic                 in_take;
    logic                 out_free;
    logic [STEP_W-1:0]    new_step;

    ctmt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .done      (div_done)
    );

    // Substitute defaults for zero rates
    assign cpu_hz_eff  = (cpu_hz_reg == '0)  ? DEFAULT_CPU_HZ  : cpu_hz_reg;
    assign tick_hz_eff = (tick_hz_reg == '0) ? DEFAULT_TICK_HZ : tick_hz_reg;

    assign in_stall      = (state_reg != S_IDLE);
    assign in_take       = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign acc_plus_frac = acc_reg + {{(US_W-CPU_HZ_W){1'b0}}, frac_reg};
    assign new_step      = div_quotient[STEP_W-1:0];

    // Config writes; an index past the list is dropped
    always_comb
    begin
        cpu_hz_next  = cpu_hz_reg;
        tick_hz_next = tick_hz_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CPU_CLOCK_HZ: cpu_hz_next  = cfg_data[CPU_HZ_W-1:0];
                CFG_TICK_RATE_HZ: tick_hz_next = cfg_data[TICK_HZ_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        prev_cyc_next  = prev_cyc_reg;
        total_next     = total_reg;
        frac_next      = frac_reg;
        max_next       = max_reg;
        step_next      = step_reg;
        millis_next    = millis_reg;
        mul_x_next     = mul_x_reg;
        acc_next       = acc_reg;
        mul_cnt_next   = mul_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_us_next    = out_us_reg;
        out_ms_next    = out_ms_reg;
        out_step_next  = out_step_reg;
        out_max_next   = out_max_reg;
        div_start      = 1'b0;
        div_dividend   = acc_plus_frac;
        div_divisor    = cpu_hz_eff;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    // Seeding scales the tick count, later words the cycle delta
                    mul_x_next    = seeded_reg ? (cycle_sample - prev_cyc_reg) : boot_ticks;
                    prev_cyc_next = cycle_sample;
                    acc_next      = '0;
                    mul_cnt_next  = MUL_CNT_W'(MUL_BITS - 1);
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                // MSB first over the bits of 1e6
                acc_next = {acc_reg[US_W-2:0], 1'b0}
                         + (US_PER_SEC[mul_cnt_reg] ? {{(US_W-CYC_W){1'b0}}, mul_x_reg}
                                                    : {US_W{1'b0}});
                mul_cnt_next = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == '0)
                begin
                    state_next = S_ADDF;
                end
            end
            S_ADDF:
            begin
                div_start    = 1'b1;
                div_dividend = acc_plus_frac;
                div_divisor  = seeded_reg ? cpu_hz_eff
                                          : {{(DIV_DEN_W-TICK_HZ_W){1'b0}}, tick_hz_eff};
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (seeded_reg)
                    begin
                        step_next  = new_step;
                        frac_next  = div_remainder;
                        total_next = total_reg + {{(US_W-STEP_W){1'b0}}, new_step};
                        if (new_step > max_reg)
                        begin
                            max_next = new_step;
                        end
                    end
                    else
                    begin
                        step_next   = '0;
                        frac_next   = '0;
                        total_next  = div_quotient;
                        seeded_next = 1'b1;
                    end
                    state_next = S_MSST;
                end
            end
            S_MSST:
            begin
                div_start    = 1'b1;
                div_dividend = total_reg;
                div_divisor  = US_PER_MS;
                state_next   = S_MS;
            end
            S_MS:
            begin
                if (div_done)
                begin
                    millis_next = div_quotient[MS_W-1:0];
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_us_next    = total_reg;
                    out_ms_next    = millis_reg;
                    out_step_next  = step_reg;
                    out_max_next   = max_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cpu_hz_reg    <= DEFAULT_CPU_HZ;
            tick_hz_reg   <= DEFAULT_TICK_HZ;
            seeded_reg    <= 1'b0;
            prev_cyc_reg  <= '0;
            total_reg     <= '0;
            frac_reg      <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cpu_hz_reg    <= cpu_hz_next;
            tick_hz_reg   <= tick_hz_next;
            seeded_reg    <= seeded_next;
            prev_cyc_reg  <= prev_cyc_next;
            total_reg     <= total_next;
            frac_reg      <= frac_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        millis_reg   <= millis_next;
        mul_x_reg    <= mul_x_next;
        acc_reg      <= acc_next;
        mul_cnt_reg  <= mul_cnt_next;
        out_us_reg   <= out_us_next;
        out_ms_reg   <= out_ms_next;
        out_step_reg <= out_step_next;
        out_max_reg  <= out_max_next;
    end

    assign out_valid       = out_valid_reg;
    assign micros_now      = out_us_reg;
    assign millis_now      = out_ms_reg;
    assign step_us         = out_step_reg;
    assign largest_step_us = out_max_reg;

endmodule

// ----- sv/ctmt_checker.sv -----
module ctmt_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [ctmt_pkg::US_W-1:0]         micros_now,
    input  logic [ctmt_pkg::MS_W-1:0]         millis_now,
    input  logic [ctmt_pkg::STEP_W-1:0]       step_us,
    input  logic [ctmt_pkg::STEP_W-1:0]       largest_step_us
);
    import ctmt_pkg::*;

    logic              out_take;
    logic              seen_reg;
    logic [US_W-1:0]   last_us_reg;
    logic [STEP_W-1:0] last_max_reg;

    assign out_take = out_valid && !out_stall;

    // Track the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (out_take)
        begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            last_us_reg  <= micros_now;
            last_max_reg <= largest_step_us;
        end
    end

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(micros_now) && $stable(millis_now)
                                   && $stable(step_us) && $stable(largest_step_us))
        else $error("stalled output word changed");

    // One word in flight: stall rises right after an accepted input word
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    a_max_covers_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> largest_step_us >= step_us)
        else $error("largest step below current step");

    // After the seeding word, the total advances by exactly the step
    a_total_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && seen_reg |-> micros_now == last_us_reg + {{(US_W-STEP_W){1'b0}}, step_us}
                                 && largest_step_us >= last_max_reg)
        else $error("total did not advance by step");

endmodule

bind cycle_to_microsecond_timebase_unit ctmt_checker u_ctmt_checker (.*);
